// File: design/nvrh_pkg.sv
// Shared types, constants and arithmetic helpers for the nearest voxel ray hit core.
`timescale 1ns / 1ps
package nvrh_pkg;

    // Field and datapath widths
    localparam int MAX_VOXELS_DEF = 4096;
    localparam int VOX_W          = 16;
    localparam int Q_W            = 32;
    localparam int DIST_W         = 31;
    localparam int FACE_W         = 3;
    localparam int SLOT_W         = 12;
    localparam int DIFF_W         = 34;
    localparam int PROD_W         = DIFF_W + Q_W;
    localparam int FRAC_W         = 16;
    localparam int QUEUE_DEPTH    = 4;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_ORG_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORG_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORG_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_INV_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_INV_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_INV_Z = 3'd5;

    localparam logic [Q_W-1:0] INV_RESET = 32'h0001_0000;

    // Entry face codes
    localparam logic [FACE_W-1:0] FACE_YP = 3'd0;
    localparam logic [FACE_W-1:0] FACE_YN = 3'd1;
    localparam logic [FACE_W-1:0] FACE_XP = 3'd2;
    localparam logic [FACE_W-1:0] FACE_XN = 3'd3;
    localparam logic [FACE_W-1:0] FACE_ZP = 3'd4;
    localparam logic [FACE_W-1:0] FACE_ZN = 3'd5;

    localparam logic signed [DIFF_W-1:0] Q_ONE_D = 34'sd65536;
    localparam logic signed [Q_W-1:0]    SAT_HI  = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0]    SAT_LO  = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VOX_W-1:0] voxel_x;
        logic signed [VOX_W-1:0] voxel_y;
        logic signed [VOX_W-1:0] voxel_z;
        logic                    last;
    } t_item;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [FACE_W-1:0] face;
        logic [SLOT_W-1:0] hit_index;
    } t_result;

    // Per-item tag carried down the back pipeline
    typedef struct packed {
        logic              last;
        logic              test;
        logic [SLOT_W-1:0] slot;
    } t_tag;

    // Queue entry between front and back
    typedef struct packed {
        t_item item;
        t_tag  tag;
    } t_qent;

    // Ray registers, axis 0 x, 1 y, 2 z
    typedef struct packed {
        logic [2:0][Q_W-1:0] org;
        logic [2:0][Q_W-1:0] inv;
    } t_ray;

    // Slab bound (v or v+1 in Q16.16) minus origin, exact in DIFF_W bits
    function automatic logic signed [DIFF_W-1:0] slab_diff(
        input logic signed [VOX_W-1:0] vox,
        input logic                    upper,
        input logic [Q_W-1:0]          org
    );
        logic signed [DIFF_W-1:0] b;
        logic signed [DIFF_W-1:0] o;
        b = {{(DIFF_W-VOX_W-FRAC_W){vox[VOX_W-1]}}, vox, {FRAC_W{1'b0}}};
        o = {{(DIFF_W-Q_W){org[Q_W-1]}}, org};
        if (upper) begin
            b = b + Q_ONE_D;
        end
        return b - o;
    endfunction

    // Floor the Q34.32 product to Q16.16 and saturate to 32 bits
    function automatic logic signed [Q_W-1:0] sat_floor(
        input logic signed [PROD_W-1:0] p
    );
        logic [PROD_W-FRAC_W-1:0] r;
        logic                     all1;
        logic                     all0;
        r    = p[PROD_W-1:FRAC_W];
        all1 = &r[PROD_W-FRAC_W-1:Q_W-1];
        all0 = ~(|r[PROD_W-FRAC_W-1:Q_W-1]);
        if (all1 || all0) begin
            return r[Q_W-1:0];
        end else if (r[PROD_W-FRAC_W-1]) begin
            return SAT_LO;
        end else begin
            return SAT_HI;
        end
    endfunction

endpackage

// File: design/nvrh_front.sv
// Front end: accepts voxel items, numbers them and marks those past the list limit.
`timescale 1ns / 1ps
module nvrh_front #(
    parameter int MAX_VOXELS = nvrh_pkg::MAX_VOXELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nvrh_pkg::t_item i_item,
    input  logic           i_qfull,
    output logic           o_qwr,
    output nvrh_pkg::t_qent o_qent
);
    import nvrh_pkg::*;

    localparam int CNT_W = $clog2(MAX_VOXELS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VOXELS);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             accept;
    logic             test;

    assign accept = i_push && !i_qfull;
    assign test   = (r_count < CNT_MAX);

    // Build the queue entry: slot number and test mark
    assign o_qwr           = accept;
    assign o_qent.item     = i_item;
    assign o_qent.tag.last = i_item.last;
    assign o_qent.tag.test = test;
    assign o_qent.tag.slot = SLOT_W'(r_count);

    // Advance the list position; restart after the last item
    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_item.last) begin
                n_count = '0;
            end else if (test) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("front list count above limit");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.last) |=> r_count == '0)
        else $error("front count not restarted after last item");

endmodule

// File: design/nvrh_fifo.sv
// Short queue that decouples the front end from the slab pipeline.
`timescale 1ns / 1ps
module nvrh_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  nvrh_pkg::t_qent i_data,
    input  logic            i_rd,
    output nvrh_pkg::t_qent o_data,
    output logic            o_full,
    output logic            o_empty
);
    import nvrh_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] CNT_FULL = (PTR_W+1)'(QUEUE_DEPTH);

    t_qent            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a write");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CNT_FULL) |-> PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// File: design/nvrh_back.sv
// Back end: slab test pipeline, running nearest-hit tracker and result register.
`timescale 1ns / 1ps
module nvrh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nvrh_pkg::t_ray    i_ray,
    input  nvrh_pkg::t_qent   i_qent,
    input  logic              i_qvalid,
    output logic              o_qrd,
    output nvrh_pkg::t_result o_result,
    output logic              o_empty,
    input  logic              i_pop
);
    import nvrh_pkg::*;

    // Stage A: bound differences
    logic                     r_a_valid;
    t_tag                     r_a_tag;
    logic                     r_a_neg [3];
    logic signed [DIFF_W-1:0] r_a_dn [3];
    logic signed [DIFF_W-1:0] r_a_df [3];
    // Stage B: products
    logic                     r_b_valid;
    t_tag                     r_b_tag;
    logic                     r_b_neg [3];
    logic signed [PROD_W-1:0] r_b_pn [3];
    logic signed [PROD_W-1:0] r_b_pf [3];
    // Stage C: saturated slab distances
    logic                     r_c_valid;
    t_tag                     r_c_tag;
    logic                     r_c_neg [3];
    logic signed [Q_W-1:0]    r_c_tn [3];
    logic signed [Q_W-1:0]    r_c_tf [3];
    // Stage D: x and y merged
    logic                     r_d_valid;
    t_tag                     r_d_tag;
    logic                     r_d_ok;
    logic signed [Q_W-1:0]    r_d_tmin;
    logic signed [Q_W-1:0]    r_d_tmax;
    logic [FACE_W-1:0]        r_d_face;
    logic                     r_d_negz;
    logic signed [Q_W-1:0]    r_d_tnz;
    logic signed [Q_W-1:0]    r_d_tfz;
    // Stage E: candidate
    logic                     r_e_valid;
    t_tag                     r_e_tag;
    logic                     r_e_cand;
    logic signed [Q_W-1:0]    r_e_tmin;
    logic [FACE_W-1:0]        r_e_face;
    // Tracker
    logic                     r_any;
    logic signed [Q_W-1:0]    r_best_dist;
    logic [FACE_W-1:0]        r_best_face;
    logic [SLOT_W-1:0]        r_best_slot;
    // Result register
    logic                     r_out_valid;
    t_result                  r_out;

    logic                     adv;
    logic signed [VOX_W-1:0]  vox [3];

    logic                     d_ok;
    logic signed [Q_W-1:0]    d_tmin;
    logic signed [Q_W-1:0]    d_tmax;
    logic [FACE_W-1:0]        d_face;
    logic                     e_ok;
    logic signed [Q_W-1:0]    e_tmin;
    logic [FACE_W-1:0]        e_face;

    logic                     take;
    logic                     n_any;
    logic signed [Q_W-1:0]    n_dist;
    logic [FACE_W-1:0]        n_face;
    logic [SLOT_W-1:0]        n_slot;
    t_result                  n_out;

    // Stall everything only when a result is due and the result register stays full
    assign adv   = !(r_e_valid && r_e_tag.last && r_out_valid && !i_pop);
    assign o_qrd = adv && i_qvalid;

    assign vox[0] = i_qent.item.voxel_x;
    assign vox[1] = i_qent.item.voxel_y;
    assign vox[2] = i_qent.item.voxel_z;

    // Stages A to C per axis
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_tag <= i_qent.tag;
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
            for (int a = 0; a < 3; a++) begin
                r_a_neg[a] <= i_ray.inv[a][Q_W-1];
                r_a_dn[a]  <= slab_diff(vox[a], i_ray.inv[a][Q_W-1], i_ray.org[a]);
                r_a_df[a]  <= slab_diff(vox[a], !i_ray.inv[a][Q_W-1], i_ray.org[a]);
                r_b_neg[a] <= r_a_neg[a];
                r_b_pn[a]  <= r_a_dn[a] * $signed(i_ray.inv[a]);
                r_b_pf[a]  <= r_a_df[a] * $signed(i_ray.inv[a]);
                r_c_neg[a] <= r_b_neg[a];
                r_c_tn[a]  <= sat_floor(r_b_pn[a]);
                r_c_tf[a]  <= sat_floor(r_b_pf[a]);
            end
        end
    end

    // Merge the x and y slabs
    always_comb begin
        d_tmin = r_c_tn[0];
        d_tmax = r_c_tf[0];
        d_face = r_c_neg[0] ? FACE_XP : FACE_XN;
        d_ok   = !(d_tmin > r_c_tf[1] || r_c_tn[1] > d_tmax);
        if (r_c_tn[1] > d_tmin) begin
            d_tmin = r_c_tn[1];
            d_face = r_c_neg[1] ? FACE_YP : FACE_YN;
        end
        if (r_c_tf[1] < d_tmax) begin
            d_tmax = r_c_tf[1];
        end
    end

    // Merge the z slab and qualify the candidate
    always_comb begin
        e_tmin = r_d_tmin;
        e_face = r_d_face;
        e_ok   = r_d_ok && !(r_d_tmin > r_d_tfz || r_d_tnz > r_d_tmax);
        if (r_d_tnz > r_d_tmin) begin
            e_tmin = r_d_tnz;
            e_face = r_d_negz ? FACE_ZP : FACE_ZN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_tag  <= r_c_tag;
            r_d_ok   <= d_ok;
            r_d_tmin <= d_tmin;
            r_d_tmax <= d_tmax;
            r_d_face <= d_face;
            r_d_negz <= r_c_neg[2];
            r_d_tnz  <= r_c_tn[2];
            r_d_tfz  <= r_c_tf[2];
            r_e_tag  <= r_d_tag;
            r_e_cand <= r_d_tag.test && e_ok && (e_tmin > 0);
            r_e_tmin <= e_tmin;
            r_e_face <= e_face;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_qvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    // Keep the nearest hit; the earlier item wins a tie
    always_comb begin
        take   = r_e_valid && r_e_cand && (!r_any || r_e_tmin < r_best_dist);
        n_any  = r_any || take;
        n_dist = take ? r_e_tmin : r_best_dist;
        n_face = take ? r_e_face : r_best_face;
        n_slot = take ? r_e_tag.slot : r_best_slot;
        n_out.hit       = n_any;
        n_out.distance  = n_any ? n_dist[DIST_W-1:0] : '0;
        n_out.face      = n_any ? n_face : '0;
        n_out.hit_index = n_any ? n_slot : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any       <= 1'b0;
            r_best_dist <= '0;
            r_best_face <= '0;
            r_best_slot <= '0;
        end else if (adv && r_e_valid) begin
            if (r_e_tag.last) begin
                r_any       <= 1'b0;
                r_best_dist <= '0;
                r_best_face <= '0;
                r_best_slot <= '0;
            end else begin
                r_any       <= n_any;
                r_best_dist <= n_dist;
                r_best_face <= n_face;
                r_best_slot <= n_slot;
            end
        end
    end

    // Result register: load on the last item, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_e_valid && r_e_tag.last) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_e_valid && r_e_tag.last) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

    a_best_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> r_best_dist > 0)
        else $error("tracked hit has non-positive distance");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.hit) |->
            (r_out.distance == '0 && r_out.face == '0 && r_out.hit_index == '0))
        else $error("miss result carries nonzero fields");

    a_hit_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hit) |-> (r_out.face <= FACE_ZN && r_out.distance != '0))
        else $error("hit result has bad face or zero distance");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_e_valid && r_e_tag.last))
        else $error("pipeline stall released the pending last item");

endmodule

// File: design/nearest_voxel_ray_hit_core.sv
// Top level: ray register port, front end, decoupling queue and slab pipeline.
// An accepted item is stored in the queue, then passes slab stages A to E into the result register.
// Throughput: one voxel item per cycle; the five-stage slab pipeline stalls only while a
// finished result waits unpopped and the next last item is due, and the queue then fills.
// Reset (synchronous, active low) empties the queue and pipeline, clears the running
// hit and list count, and sets the ray to origin 0 and inverse direction 1.0.
`timescale 1ns / 1ps
module nearest_voxel_ray_hit_core #(
    parameter int MAX_VOXELS = nvrh_pkg::MAX_VOXELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  nvrh_pkg::t_item              i_item,
    output logic                         empty,
    input  logic                         pop,
    output nvrh_pkg::t_result            o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nvrh_pkg::ADDR_W-1:0]  paddr,
    input  logic [nvrh_pkg::DATA_W-1:0]  pwdata,
    output logic [nvrh_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import nvrh_pkg::*;

    t_ray             r_ray;
    logic [IDX_W-1:0] reg_idx;
    logic             cfg_wr;
    logic             q_wr;
    t_qent            q_wdata;
    t_qent            q_rdata;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Ray register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.org <= '0;
            r_ray.inv <= {3{INV_RESET}};
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ORG_X: r_ray.org[0] <= pwdata;
                REG_ORG_Y: r_ray.org[1] <= pwdata;
                REG_ORG_Z: r_ray.org[2] <= pwdata;
                REG_INV_X: r_ray.inv[0] <= pwdata;
                REG_INV_Y: r_ray.inv[1] <= pwdata;
                REG_INV_Z: r_ray.inv[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            REG_ORG_X: prdata = r_ray.org[0];
            REG_ORG_Y: prdata = r_ray.org[1];
            REG_ORG_Z: prdata = r_ray.org[2];
            REG_INV_X: prdata = r_ray.inv[0];
            REG_INV_Y: prdata = r_ray.inv[1];
            REG_INV_Z: prdata = r_ray.inv[2];
            default:   prdata = '0;
        endcase
    end

    assign full = q_full;

    nvrh_front #(
        .MAX_VOXELS(MAX_VOXELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_qfull (q_full),
        .o_qwr   (q_wr),
        .o_qent  (q_wdata)
    );

    nvrh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wdata),
        .i_rd    (q_rd),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    nvrh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ray    (r_ray),
        .i_qent   (q_rdata),
        .i_qvalid (!q_empty),
        .o_qrd    (q_rd),
        .o_result (o_result),
        .o_empty  (empty),
        .i_pop    (pop)
    );

endmodule

// File: sim/nvrh_hit_checker.sv
// Checker for the nearest voxel ray hit core: tracks the ray registers and checks each result.
`timescale 1ns / 1ps
module nvrh_hit_checker #(
    parameter int MAX_VOXELS = nvrh_pkg::MAX_VOXELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  nvrh_pkg::t_item             i_item,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  nvrh_pkg::t_result           i_result,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [nvrh_pkg::ADDR_W-1:0] i_paddr,
    input  logic [nvrh_pkg::DATA_W-1:0] i_pwdata,
    input  logic [nvrh_pkg::DATA_W-1:0] i_prdata,
    output int                          o_pending,
    output int                          o_errors
);
    import nvrh_pkg::*;

    // Ray registers as the block should hold them
    logic signed [Q_W-1:0] ray_org [3];
    logic signed [Q_W-1:0] ray_inv [3];
    logic [IDX_W-1:0]      reg_idx;
    logic [DATA_W-1:0]     reg_value;

    // Running nearest hit of the current voxel list
    logic signed [Q_W-1:0] best_dist;
    logic [FACE_W-1:0]     best_face;
    logic [SLOT_W-1:0]     best_slot;
    logic                  any_hit;
    int                    list_len;

    t_result               nearest_hits [$];
    int                    errors = 0;

    // Slab distance: (bound - origin) * inverse, floored to Q16.16 and saturated
    function automatic logic signed [Q_W-1:0] slab_time(
        input logic signed [DIFF_W-1:0] gap,
        input logic signed [Q_W-1:0]    inv
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] floored;
        prod    = gap * inv;
        floored = prod >>> FRAC_W;
        if (floored > SAT_HI) begin
            return SAT_HI;
        end
        if (floored < SAT_LO) begin
            return SAT_LO;
        end
        return floored[Q_W-1:0];
    endfunction

    // Near and far distance on one axis; returns 1 for a negative direction
    function automatic logic axis_span(
        input  logic signed [VOX_W-1:0] vox,
        input  logic signed [Q_W-1:0]   org,
        input  logic signed [Q_W-1:0]   inv,
        output logic signed [Q_W-1:0]   t_near,
        output logic signed [Q_W-1:0]   t_far
    );
        logic signed [DIFF_W-1:0] lo_edge;
        logic signed [DIFF_W-1:0] hi_edge;
        logic signed [DIFF_W-1:0] org_w;
        lo_edge = vox;
        lo_edge = lo_edge <<< FRAC_W;
        hi_edge = lo_edge + Q_ONE_D;
        org_w   = org;
        if (inv < 0) begin
            t_near = slab_time(hi_edge - org_w, inv);
            t_far  = slab_time(lo_edge - org_w, inv);
        end else begin
            t_near = slab_time(lo_edge - org_w, inv);
            t_far  = slab_time(hi_edge - org_w, inv);
        end
        return inv < 0;
    endfunction

    // Slab-test one voxel, update the nearest hit, emit a result item on last
    task automatic track_voxel(input t_item it);
        logic signed [Q_W-1:0] t_min;
        logic signed [Q_W-1:0] t_max;
        logic signed [Q_W-1:0] t_near;
        logic signed [Q_W-1:0] t_far;
        logic [FACE_W-1:0]     face;
        logic                  crossed;
        logic                  neg;
        t_result               res;
        if (list_len < MAX_VOXELS) begin
            neg  = axis_span(it.voxel_x, ray_org[0], ray_inv[0], t_min, t_max);
            face = neg ? FACE_XP : FACE_XN;
            neg  = axis_span(it.voxel_y, ray_org[1], ray_inv[1], t_near, t_far);
            crossed = !(t_min > t_far || t_near > t_max);
            if (crossed) begin
                if (t_near > t_min) begin
                    t_min = t_near;
                    face  = neg ? FACE_YP : FACE_YN;
                end
                if (t_far < t_max) begin
                    t_max = t_far;
                end
                neg = axis_span(it.voxel_z, ray_org[2], ray_inv[2], t_near, t_far);
                crossed = !(t_min > t_far || t_near > t_max);
                if (crossed && t_near > t_min) begin
                    t_min = t_near;
                    face  = neg ? FACE_ZP : FACE_ZN;
                end
            end
            // keep strictly nearer hits only, so the earliest voxel wins a tie
            if (crossed && t_min > 0 && (!any_hit || t_min < best_dist)) begin
                best_dist = t_min;
                best_face = face;
                best_slot = SLOT_W'(list_len);
                any_hit   = 1'b1;
            end
            list_len++;
        end
        if (it.last) begin
            res.hit       = any_hit;
            res.distance  = any_hit ? best_dist[DIST_W-1:0] : '0;
            res.face      = any_hit ? best_face : '0;
            res.hit_index = any_hit ? best_slot : '0;
            nearest_hits  = {nearest_hits, res};
            best_dist = '0;
            best_face = '0;
            best_slot = '0;
            any_hit   = 1'b0;
            list_len  = 0;
        end
    endtask

    // Compare one popped result item with the oldest expected one
    task automatic check_result(input t_result got);
        t_result want;
        if (nearest_hits.size() == 0) begin
            if (errors < 10) begin
                $display("unexpected result item: hit=%0d dist=%h face=%0d idx=%0d",
                         got.hit, got.distance, got.face, got.hit_index);
            end
            errors++;
        end else begin
            want = nearest_hits.pop_front();
            if (got.hit !== want.hit || got.distance !== want.distance ||
                got.face !== want.face || got.hit_index !== want.hit_index) begin
                if (errors < 10) begin
                    $display("result mismatch: expected hit=%0d dist=%h face=%0d idx=%0d",
                             want.hit, want.distance, want.face, want.hit_index);
                    $display("                 actual   hit=%0d dist=%h face=%0d idx=%0d",
                             got.hit, got.distance, got.face, got.hit_index);
                end
                errors++;
            end
        end
    endtask

    // Follow the register port and both item channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                ray_org[a] = '0;
                ray_inv[a] = INV_RESET;
            end
            best_dist = '0;
            best_face = '0;
            best_slot = '0;
            any_hit   = 1'b0;
            list_len  = 0;
            nearest_hits.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                reg_idx = i_paddr[ADDR_W-1:2];
                if (reg_idx <= REG_INV_Z) begin
                    if (i_pwrite) begin
                        if (reg_idx < REG_INV_X) begin
                            ray_org[reg_idx] = i_pwdata;
                        end else begin
                            ray_inv[reg_idx - REG_INV_X] = i_pwdata;
                        end
                    end else begin
                        reg_value = (reg_idx < REG_INV_X) ? ray_org[reg_idx]
                                                          : ray_inv[reg_idx - REG_INV_X];
                        if (i_prdata !== reg_value) begin
                            if (errors < 10) begin
                                $display("register %0d readback: expected %h actual %h",
                                         reg_idx, reg_value, i_prdata);
                            end
                            errors++;
                        end
                    end
                end
            end
            if (i_pop && !i_empty) begin
                check_result(i_result);
            end
            if (i_push && !i_full) begin
                track_voxel(i_item);
            end
        end
        o_pending <= nearest_hits.size();
        o_errors  <= errors;
    end

endmodule

// File: sim/tb_nearest_voxel_ray_hit_core.sv
// Testbench top for the nearest voxel ray hit core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_nearest_voxel_ray_hit_core;
    import nvrh_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 100;

    localparam logic [IDX_W-1:0] REG_SPARE_A = REG_INV_Z + 3'd1;
    localparam logic [IDX_W-1:0] REG_SPARE_B = REG_INV_Z + 3'd2;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push    = 1'b0;
    logic              pop     = 1'b0;
    t_item             voxel_item = '0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic              full;
    logic              empty;
    logic              pready;
    logic [DATA_W-1:0] prdata;
    t_result           hit_item;

    int    hits_waiting;
    int    hit_errors;
    int    cycle_count = 0;
    int    pop_hold    = 0;
    logic  push_steady = 1'b1;
    logic  pop_steady  = 1'b1;
    t_ray  cur_ray;

    nearest_voxel_ray_hit_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (voxel_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (hit_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    nvrh_hit_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_item    (voxel_item),
        .i_empty   (empty),
        .i_pop     (pop),
        .i_result  (hit_item),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_prdata  (prdata),
        .o_pending (hits_waiting),
        .o_errors  (hit_errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    // Result side: pop with random stalls unless in a steady stretch
    always @(posedge i_clk) begin
        pop <= (pop_hold == 0);
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
        end else begin
            pop_hold <= pop_steady ? 0 : idle_gap();
        end
    end

    // One register access: setup cycle, access cycle, then one idle cycle
    task automatic reg_access(input logic wr, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all six ray registers and a spare index, then read the ray back
    task automatic load_ray(input t_ray ray);
        cur_ray = ray;
        for (int a = 0; a < 3; a++) begin
            reg_access(1'b1, REG_ORG_X + IDX_W'(a), ray.org[a]);
            reg_access(1'b1, REG_INV_X + IDX_W'(a), ray.inv[a]);
        end
        reg_access(1'b1, $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        for (int r = 0; r < 6; r++) begin
            reg_access(1'b0, REG_ORG_X + IDX_W'(r), '0);
        end
    endtask

    // Offer one voxel item and hold it until accepted
    task automatic send_voxel(input t_item it);
        int gap;
        gap = push_steady ? 0 : idle_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        voxel_item <= it;
        push       <= 1'b1;
        do @(posedge i_clk); while (full);
    endtask

    // Drop push, wait for every result item, then let the pipeline drain
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (hits_waiting != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_item voxel(input int x, input int y, input int z, input logic last);
        t_item it;
        it.voxel_x = x[VOX_W-1:0];
        it.voxel_y = y[VOX_W-1:0];
        it.voxel_z = z[VOX_W-1:0];
        it.last    = last;
        return it;
    endfunction

    function automatic t_ray make_ray(input logic [Q_W-1:0] ox, input logic [Q_W-1:0] oy,
                                      input logic [Q_W-1:0] oz, input logic [Q_W-1:0] ix,
                                      input logic [Q_W-1:0] iy, input logic [Q_W-1:0] iz);
        t_ray r;
        r.org[0] = ox;
        r.org[1] = oy;
        r.org[2] = oz;
        r.inv[0] = ix;
        r.inv[1] = iy;
        r.inv[2] = iz;
        return r;
    endfunction

    // Voxel near a random point along the current ray, jittered by one cell
    function automatic t_item ray_voxel();
        t_item                  it;
        real                    t;
        real                    o;
        real                    d;
        real                    c;
        int                     ci;
        logic [2:0][VOX_W-1:0] v;
        t = $urandom_range(0, 4000) / 100.0;
        for (int a = 0; a < 3; a++) begin
            o = $signed(cur_ray.org[a]);
            o = o / 65536.0;
            d = $signed(cur_ray.inv[a]);
            d = (cur_ray.inv[a] == '0) ? 0.0 : 65536.0 / d;
            c = $floor(o + t * d) + $urandom_range(0, 2) - 1.0;
            if (c > 32767.0) begin
                c = 32767.0;
            end
            if (c < -32768.0) begin
                c = -32768.0;
            end
            ci   = $rtoi(c);
            v[a] = ci[VOX_W-1:0];
        end
        it.voxel_x = v[0];
        it.voxel_y = v[1];
        it.voxel_z = v[2];
        it.last    = 1'b0;
        return it;
    endfunction

    // Random ray: either corner values or a plain ray near the world origin
    function automatic t_ray random_ray(input logic extreme);
        t_ray        r;
        logic [31:0] mag;
        for (int a = 0; a < 3; a++) begin
            if (extreme) begin
                case ($urandom_range(0, 3))
                    0:       r.org[a] = 32'h8000_0000;
                    1:       r.org[a] = 32'h7FFF_FFFF;
                    2:       r.org[a] = '0;
                    default: r.org[a] = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0:       r.inv[a] = 32'h8000_0000;
                    1:       r.inv[a] = 32'h7FFF_FFFF;
                    2:       r.inv[a] = '0;
                    3:       r.inv[a] = 32'hFFFF_FFFF;
                    4:       r.inv[a] = 32'h0000_0001;
                    default: r.inv[a] = $urandom;
                endcase
            end else begin
                r.org[a] = $urandom_range(0, 60 * 65536) - 30 * 65536;
                mag      = $urandom_range(3277, 8 * 65536);
                if ($urandom_range(0, 11) == 0) begin
                    r.inv[a] = '0;
                end else begin
                    r.inv[a] = $urandom_range(0, 1) ? -mag : mag;
                end
            end
        end
        return r;
    endfunction

    initial begin
        t_item it;
        int    sent;
        int    len;

        cur_ray = make_ray('0, '0, '0, INV_RESET, INV_RESET, INV_RESET);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset ray along +1,+1,+1: ties, a zero distance, field extremes, y and z entry
        send_voxel(voxel(5, 5, 5, 1'b0));
        send_voxel(voxel(1, 1, 1, 1'b0));
        send_voxel(voxel(2, 2, 2, 1'b0));
        send_voxel(voxel(1, 1, 1, 1'b1));
        send_voxel(voxel(0, 0, 0, 1'b1));
        send_voxel(voxel(32767, 32767, 32767, 1'b0));
        send_voxel(voxel(-32768, -32768, -32768, 1'b1));
        send_voxel(voxel(1, 0, 0, 1'b0));
        send_voxel(voxel(-1, -1, -1, 1'b1));
        send_voxel(voxel(3, 4, 3, 1'b1));
        send_voxel(voxel(3, 3, 4, 1'b1));
        settle();

        // Zero inverse direction on z
        load_ray(make_ray(32'h000A_8000, 32'h0014_8000, 32'h0000_4000,
                          32'hFFFF_0000, 32'hFFFE_0000, '0));
        send_voxel(voxel(5, 10, 0, 1'b0));
        send_voxel(voxel(4, 0, 0, 1'b1));
        send_voxel(voxel(32767, -32768, 0, 1'b1));
        settle();

        // Negative direction on every axis
        load_ray(make_ray(32'h000A_8000, 32'h000A_8000, 32'h000A_8000,
                          32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
        send_voxel(voxel(5, 4, 5, 1'b0));
        send_voxel(voxel(5, 5, 4, 1'b0));
        send_voxel(voxel(5, 5, 5, 1'b1));
        settle();

        // Saturating products
        load_ray(make_ray('0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_voxel(voxel(1, 1, 1, 1'b0));
        send_voxel(voxel(-32768, -32768, -32768, 1'b1));
        settle();

        // Random phases: lists along the ray, mixed with noise items
        for (int phase = 0; phase < 8; phase++) begin
            push_steady = ($urandom_range(0, 2) == 0);
            pop_steady  = ($urandom_range(0, 2) == 0);
            load_ray(random_ray(phase % 4 == 3));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        it.voxel_x = 16'($urandom);
                        it.voxel_y = 16'($urandom);
                        it.voxel_z = 16'($urandom);
                        it.last    = ($urandom_range(0, 7) == 0);
                    end else begin
                        it = ray_voxel();
                    end
                    if (k == len - 1) begin
                        it.last = 1'b1;
                    end
                    send_voxel(it);
                    sent++;
                end
            end
            settle();
        end

        if (hit_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
